// ===== rtl/ptdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptdt_pkg: shared types and constants of the periodic task dispatch table
// Table geometry, command and result codes, and the control and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ptdt_pkg;

	localparam int TASKS_PER_CLASS = 16;
	localparam int NUM_CLASSES     = 3;
	localparam int DEPTH           = NUM_CLASSES * TASKS_PER_CLASS;
	localparam int AW              = $clog2(DEPTH);
	localparam int IW              = $clog2(TASKS_PER_CLASS + 1);

	// input commands
	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_DEL  = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;
	localparam logic [1:0] CMD_POLL = 2'd3;

	// task classes
	localparam logic [1:0] CLS_ALWAYS  = 2'd0;
	localparam logic [1:0] CLS_POLLED  = 2'd1;
	localparam logic [1:0] CLS_IRQ     = 2'd2;
	localparam logic [1:0] CLS_INVALID = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_FIRED  = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	// write data select
	localparam logic [1:0] WS_UPDATE = 2'd0;
	localparam logic [1:0] WS_SHIFT  = 2'd1;
	localparam logic [1:0] WS_ADV    = 2'd2;

	typedef struct packed {
		logic [7:0]  id;
		logic [31:0] period;
		logic [31:0] counter;
	} entry_t;

	typedef struct packed {
		logic       latch;
		logic       idx_clr;
		logic       idx_inc;
		logic       wcls_ld;
		logic [1:0] wcls_val;
		logic       rd_en;
		logic       rd_next;
		logic       wr_en;
		logic [1:0] wr_sel;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       pend_set;
		logic       pend_clr;
		logic       ok_ld;
		logic       ok_val;
		logic       emit;
		logic [1:0] emit_kind;
	} ctrl_t;

	typedef struct packed {
		logic [1:0] command;
		logic [1:0] cls;
		logic       id_zero;
		logic       cls_bad;
		logic       pending;
		logic       at_end;
		logic       shift_end;
		logic       full;
		logic       hit;
		logic       fire;
		logic       out_free;
		logic [1:0] wcls;
	} stat_t;

endpackage
`default_nettype wire

// ===== rtl/ptdt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptdt_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
module ptdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ptdt_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptdt_dp: datapath of the dispatch table
// Entry RAM, per-class fill counts, tick pending flag, walk index and the
// result register.
// ----------------------------------------------------------------------------
module ptdt_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ptdt_pkg::ctrl_t ctrl,
	output ptdt_pkg::stat_t      stat,
	input  wire logic [1:0]      command,
	input  wire logic [1:0]      task_class,
	input  wire logic [7:0]      task_id,
	input  wire logic [31:0]     period_ticks,
	output logic                 res_valid,
	input  wire logic            res_stall,
	output logic [1:0]           result_kind,
	output logic                 success,
	output logic [7:0]           fired_id,
	output logic [1:0]           fired_class,
	output logic                 last
);

	logic [1:0]              command_q;
	logic [1:0]              cls_q;
	logic [7:0]              id_q;
	logic [31:0]             period_q;
	logic [1:0]              wcls_q;
	logic [ptdt_pkg::IW-1:0] idx_q;
	logic [ptdt_pkg::IW-1:0] count_q [ptdt_pkg::NUM_CLASSES];
	logic                    pending_q;
	logic                    ok_q;
	logic                    res_valid_q;

	logic [ptdt_pkg::IW-1:0] cur_count;
	logic [ptdt_pkg::AW-1:0] base;
	logic [ptdt_pkg::AW-1:0] wr_addr;
	logic [ptdt_pkg::AW-1:0] rd_addr;
	ptdt_pkg::entry_t        rd_entry;
	ptdt_pkg::entry_t        wr_entry;
	logic [31:0]             next_counter;
	logic                    out_free;

	always_comb begin
		case (wcls_q)
			ptdt_pkg::CLS_ALWAYS: begin
				cur_count = count_q[0];
				base      = '0;
			end
			ptdt_pkg::CLS_POLLED: begin
				cur_count = count_q[1];
				base      = ptdt_pkg::AW'(ptdt_pkg::TASKS_PER_CLASS);
			end
			ptdt_pkg::CLS_IRQ: begin
				cur_count = count_q[2];
				base      = ptdt_pkg::AW'(2 * ptdt_pkg::TASKS_PER_CLASS);
			end
			default: begin
				cur_count = '0;
				base      = '0;
			end
		endcase
	end

	assign wr_addr      = base + ptdt_pkg::AW'(idx_q);
	assign rd_addr      = wr_addr + (ctrl.rd_next ? ptdt_pkg::AW'(1) : ptdt_pkg::AW'(0));
	assign next_counter = rd_entry.counter + 32'd1;
	assign out_free     = !res_valid_q || !res_stall;

	always_comb begin
		case (ctrl.wr_sel)
			ptdt_pkg::WS_SHIFT: begin
				wr_entry = rd_entry;
			end
			ptdt_pkg::WS_ADV: begin
				wr_entry.id      = rd_entry.id;
				wr_entry.period  = rd_entry.period;
				wr_entry.counter = (next_counter == rd_entry.period) ? 32'd0 : next_counter;
			end
			default: begin
				wr_entry.id      = id_q;
				wr_entry.period  = period_q;
				wr_entry.counter = 32'd0;
			end
		endcase
	end

	ptdt_ram #(
		.WIDTH($bits(ptdt_pkg::entry_t)),
		.DEPTH(ptdt_pkg::DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ctrl.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en  (ctrl.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_entry)
	);

	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			command_q <= command;
			cls_q     <= task_class;
			id_q      <= task_id;
			period_q  <= period_ticks;
		end
		if (ctrl.idx_clr) begin
			idx_q <= '0;
		end else if (ctrl.idx_inc) begin
			idx_q <= idx_q + ptdt_pkg::IW'(1);
		end
		if (ctrl.wcls_ld) begin
			wcls_q <= ctrl.wcls_val;
		end
		if (ctrl.ok_ld) begin
			ok_q <= ctrl.ok_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < ptdt_pkg::NUM_CLASSES; c++) begin
				count_q[c] <= '0;
			end
			pending_q <= 1'b0;
		end else begin
			for (int c = 0; c < ptdt_pkg::NUM_CLASSES; c++) begin
				if (wcls_q == 2'(c)) begin
					if (ctrl.cnt_inc) begin
						count_q[c] <= count_q[c] + ptdt_pkg::IW'(1);
					end else if (ctrl.cnt_dec) begin
						count_q[c] <= count_q[c] - ptdt_pkg::IW'(1);
					end
				end
			end
			if (ctrl.pend_set) begin
				pending_q <= 1'b1;
			end else if (ctrl.pend_clr) begin
				pending_q <= 1'b0;
			end
		end
	end

	// result register: load on emit, drop once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			result_kind <= ctrl.emit_kind;
			success     <= (ctrl.emit_kind == ptdt_pkg::KIND_STATUS) ? ok_q : 1'b0;
			fired_id    <= (ctrl.emit_kind == ptdt_pkg::KIND_FIRED) ? rd_entry.id : 8'd0;
			fired_class <= (ctrl.emit_kind == ptdt_pkg::KIND_FIRED) ? wcls_q : 2'd0;
			last        <= (ctrl.emit_kind != ptdt_pkg::KIND_FIRED);
		end
	end

	assign res_valid = res_valid_q;

	assign stat.command   = command_q;
	assign stat.cls       = cls_q;
	assign stat.id_zero   = (id_q == 8'd0);
	assign stat.cls_bad   = (cls_q == ptdt_pkg::CLS_INVALID);
	assign stat.pending   = pending_q;
	assign stat.at_end    = (idx_q == cur_count);
	assign stat.shift_end = ((idx_q + ptdt_pkg::IW'(1)) == cur_count);
	assign stat.full      = (cur_count >= ptdt_pkg::IW'(ptdt_pkg::TASKS_PER_CLASS));
	assign stat.hit       = (rd_entry.id == id_q);
	assign stat.fire      = (next_counter == rd_entry.period);
	assign stat.out_free  = out_free;
	assign stat.wcls      = wcls_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> out_free)
		else $error("result emitted over a stalled beat");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q[0] <= ptdt_pkg::IW'(ptdt_pkg::TASKS_PER_CLASS)) &&
		(count_q[1] <= ptdt_pkg::IW'(ptdt_pkg::TASKS_PER_CLASS)) &&
		(count_q[2] <= ptdt_pkg::IW'(ptdt_pkg::TASKS_PER_CLASS)))
		else $error("class count beyond table size");

	a_append_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.cnt_inc |-> (ctrl.wr_en && idx_q == cur_count))
		else $error("append not at end of table");

	a_delete_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.cnt_dec |-> (cur_count != '0))
		else $error("delete from empty table");

endmodule
`default_nettype wire

// ===== rtl/ptdt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptdt_ctrl: command sequencer of the dispatch table
// Decodes one command and steps the datapath through searches, deletes with
// compaction, counter walks and the always-run listing.
// ----------------------------------------------------------------------------
module ptdt_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_stall,
	input  wire ptdt_pkg::stat_t stat,
	output ptdt_pkg::ctrl_t      ctrl
);

	localparam logic [3:0] S_START    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_DECODE   = 4'd2;
	localparam logic [3:0] S_SRCH_RD  = 4'd3;
	localparam logic [3:0] S_SRCH_CHK = 4'd4;
	localparam logic [3:0] S_SHIFT_RD = 4'd5;
	localparam logic [3:0] S_SHIFT_WR = 4'd6;
	localparam logic [3:0] S_ADV_RD   = 4'd7;
	localparam logic [3:0] S_ADV_WR   = 4'd8;
	localparam logic [3:0] S_LIST_RD  = 4'd9;
	localparam logic [3:0] S_LIST_EM  = 4'd10;
	localparam logic [3:0] S_STATUS   = 4'd11;
	localparam logic [3:0] S_END      = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_START;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd_stall = (state_q != S_IDLE);

	always_comb begin
		ctrl    = '0;
		state_d = state_q;
		case (state_q)
			S_START: begin
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cmd_valid) begin
					ctrl.latch = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				ctrl.idx_clr = 1'b1;
				case (stat.command)
					ptdt_pkg::CMD_ADD, ptdt_pkg::CMD_DEL: begin
						if (stat.id_zero || stat.cls_bad) begin
							ctrl.ok_ld  = 1'b1;
							ctrl.ok_val = 1'b0;
							state_d     = S_STATUS;
						end else begin
							ctrl.wcls_ld  = 1'b1;
							ctrl.wcls_val = stat.cls;
							state_d       = S_SRCH_RD;
						end
					end
					ptdt_pkg::CMD_TICK: begin
						ctrl.pend_set = 1'b1;
						ctrl.wcls_ld  = 1'b1;
						ctrl.wcls_val = ptdt_pkg::CLS_IRQ;
						state_d       = S_ADV_RD;
					end
					default: begin
						ctrl.wcls_ld = 1'b1;
						if (stat.pending) begin
							ctrl.pend_clr = 1'b1;
							ctrl.wcls_val = ptdt_pkg::CLS_POLLED;
							state_d       = S_ADV_RD;
						end else begin
							ctrl.wcls_val = ptdt_pkg::CLS_ALWAYS;
							state_d       = S_LIST_RD;
						end
					end
				endcase
			end
			S_SRCH_RD: begin
				if (stat.at_end) begin
					ctrl.ok_ld = 1'b1;
					state_d    = S_STATUS;
					// id absent: an add appends if there is room, else the command fails
					if (stat.command == ptdt_pkg::CMD_ADD && !stat.full) begin
						ctrl.wr_en   = 1'b1;
						ctrl.wr_sel  = ptdt_pkg::WS_UPDATE;
						ctrl.cnt_inc = 1'b1;
						ctrl.ok_val  = 1'b1;
					end
				end else begin
					ctrl.rd_en = 1'b1;
					state_d    = S_SRCH_CHK;
				end
			end
			S_SRCH_CHK: begin
				if (stat.hit) begin
					if (stat.command == ptdt_pkg::CMD_ADD) begin
						ctrl.wr_en  = 1'b1;
						ctrl.wr_sel = ptdt_pkg::WS_UPDATE;
						ctrl.ok_ld  = 1'b1;
						ctrl.ok_val = 1'b1;
						state_d     = S_STATUS;
					end else begin
						state_d = S_SHIFT_RD;
					end
				end else begin
					ctrl.idx_inc = 1'b1;
					state_d      = S_SRCH_RD;
				end
			end
			S_SHIFT_RD: begin
				if (stat.shift_end) begin
					ctrl.cnt_dec = 1'b1;
					ctrl.ok_ld   = 1'b1;
					ctrl.ok_val  = 1'b1;
					state_d      = S_STATUS;
				end else begin
					ctrl.rd_en   = 1'b1;
					ctrl.rd_next = 1'b1;
					state_d      = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				ctrl.wr_en   = 1'b1;
				ctrl.wr_sel  = ptdt_pkg::WS_SHIFT;
				ctrl.idx_inc = 1'b1;
				state_d      = S_SHIFT_RD;
			end
			S_ADV_RD: begin
				if (stat.at_end) begin
					if (stat.wcls == ptdt_pkg::CLS_POLLED) begin
						// poll continues with the always-run listing
						ctrl.idx_clr  = 1'b1;
						ctrl.wcls_ld  = 1'b1;
						ctrl.wcls_val = ptdt_pkg::CLS_ALWAYS;
						state_d       = S_LIST_RD;
					end else begin
						state_d = S_END;
					end
				end else begin
					ctrl.rd_en = 1'b1;
					state_d    = S_ADV_WR;
				end
			end
			S_ADV_WR: begin
				// hold a firing entry until the result slot is free
				if (!stat.fire || stat.out_free) begin
					ctrl.wr_en     = 1'b1;
					ctrl.wr_sel    = ptdt_pkg::WS_ADV;
					ctrl.idx_inc   = 1'b1;
					ctrl.emit      = stat.fire;
					ctrl.emit_kind = ptdt_pkg::KIND_FIRED;
					state_d        = S_ADV_RD;
				end
			end
			S_LIST_RD: begin
				if (stat.at_end) begin
					state_d = S_END;
				end else begin
					ctrl.rd_en = 1'b1;
					state_d    = S_LIST_EM;
				end
			end
			S_LIST_EM: begin
				if (stat.out_free) begin
					ctrl.emit      = 1'b1;
					ctrl.emit_kind = ptdt_pkg::KIND_FIRED;
					ctrl.idx_inc   = 1'b1;
					state_d        = S_LIST_RD;
				end
			end
			S_STATUS: begin
				if (stat.out_free) begin
					ctrl.emit      = 1'b1;
					ctrl.emit_kind = ptdt_pkg::KIND_STATUS;
					state_d        = S_IDLE;
				end
			end
			S_END: begin
				if (stat.out_free) begin
					ctrl.emit      = 1'b1;
					ctrl.emit_kind = ptdt_pkg::KIND_END;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/periodic_task_dispatch_table.sv =====
// Periodic task dispatch table.
// Command channel (cmd_valid / cmd_stall) carries command, task_class,
// task_id and period_ticks; a beat is taken when cmd_valid is high and
// cmd_stall is low. Result channel (res_valid / res_stall) carries
// result_kind, success, fired_id, fired_class and last, one beat per result.
// One command is worked at a time; cmd_stall stays high until its final
// result (last = 1) has been loaded into the result register.
// The next command can be taken in the cycle after that load. A class holds
// at most 16 entries. A rejected add or delete (id zero, invalid class) goes
// straight to its status; any other add or delete searches the class for
// the id, and a delete shifts the later entries down. A tick walks the irq
// class; a poll lists the always-run class, after walking the polled class
// if a tick is pending. Each slot is read from the entry RAM (registered
// read data) in one state and compared, written back or emitted in the next.
// The result register frees the sequencer as soon as a beat is loaded; a
// stalling receiver holds the current beat and pauses the walk at the next
// result. After reset all tables are empty and no tick is pending; cmd_stall
// is high for the first cycle after reset release.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_dispatch_table: top level
// Joins the command sequencer and the table datapath.
// ----------------------------------------------------------------------------
module periodic_task_dispatch_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire logic [1:0]  command,
	input  wire logic [1:0]  task_class,
	input  wire logic [7:0]  task_id,
	input  wire logic [31:0] period_ticks,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [1:0]       result_kind,
	output logic             success,
	output logic [7:0]       fired_id,
	output logic [1:0]       fired_class,
	output logic             last
);

	ptdt_pkg::ctrl_t ctrl;
	ptdt_pkg::stat_t stat;

	ptdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	ptdt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.command     (command),
		.task_class  (task_class),
		.task_id     (task_id),
		.period_ticks(period_ticks),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.result_kind (result_kind),
		.success     (success),
		.fired_id    (fired_id),
		.fired_class (fired_class),
		.last        (last)
	);

endmodule
`default_nettype wire
